>>> sv/bra_pkg.sv
// Shared types and codes for the bitmap run allocator.
// Command and result beat layouts, function and status codes, fixed widths.
// No dependencies.
`default_nettype none

package bra_pkg;

    // Fixed field widths
    localparam int FUNC_W   = 2;
    localparam int SIZE_W   = 14;
    localparam int OFFSET_W = 13;
    localparam int STATUS_W = 2;
    localparam int USED_W   = 8;
    localparam int PCT_W    = 7;

    // Rounded size needs one bit more than the size field
    localparam int DIV_W = SIZE_W + 1;

    // Function codes
    localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_COMPACT = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_RUN = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE  = 2'd2;

    // Occupancy threshold register reset and percent scale
    localparam logic [PCT_W-1:0] PCT_RESET = 7'd50;
    localparam int               PCT_SCALE = 100;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [SIZE_W-1:0]   size_bytes;
        logic [OFFSET_W-1:0] offset_bytes;
    } bra_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFFSET_W-1:0] result_offset;
        logic [USED_W-1:0]   used_granules;
        logic                frozen;
    } bra_rsp_t;

endpackage

`default_nettype wire

>>> sv/bra_recip_div.sv
// Registered divide by a fixed constant, done as a reciprocal multiply.
// Exact for every dividend below 2**DIV_W. Depends on bra_pkg.
`default_nettype none

module bra_recip_div #(
    parameter int DIVISOR = 64
) (
    input  wire logic                      clk,
    input  wire logic [bra_pkg::DIV_W-1:0] dividend,
    output logic      [bra_pkg::DIV_W-1:0] quotient
);
    import bra_pkg::*;

    // Round-up reciprocal: m = ceil(2**(N+l) / d), l = ceil(log2 d)
    localparam int L_BITS = (DIVISOR > 1) ? $clog2(DIVISOR) : 0;
    localparam int SHIFT  = DIV_W + L_BITS;
    localparam int RECIP  = ((2 ** SHIFT) + DIVISOR - 1) / DIVISOR;
    localparam int PROD_W = 2 * DIV_W + 1;

    logic [PROD_W-1:0] product;

    // One multiply, then the shift picks the quotient
    assign product = PROD_W'(dividend) * PROD_W'(RECIP);

    // Register the quotient
    always_ff @(posedge clk)
    begin
        quotient <= DIV_W'(product >> SHIFT);
    end

endmodule

`default_nettype wire

>>> sv/bra_bitmap.sv
// Free bitmap storage: one bit per granule, 1 means free.
// One write port and one read port with registered read data. No package use.
`default_nettype none

module bra_bitmap #(
    parameter int DEPTH = 128,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic          wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic               rd_data
);

    logic map_mem [DEPTH];

    // Write one granule bit
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[wr_addr] <= wr_data;
        end
    end

    // Read one granule bit, data valid next cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= map_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> sv/bitmap_run_allocator_top.sv
// Top level of the bitmap run allocator: command sequencer, used count and freeze state.
// Uses bra_pkg, bra_recip_div and bra_bitmap.
//
// First-fit allocator over one segment of GRANULES granules of GRANULE_BYTES bytes.
// A command beat is taken when start is high and busy is low; its result appears
// on result for exactly one cycle with done high and must be taken then. Every
// command passes through the decode states S_DIVN, S_DIVF and S_DECIDE (two
// passes through the reciprocal divider) and ends in S_REPORT. In between,
// alloc scans the bitmap one granule per cycle through the memory read port
// and marks the found run one granule per cycle on the write port. Free marks
// up to the rounded size, capped at the segment end, one granule per cycle.
// Clear rewrites the whole bitmap. After reset the block runs a clearing pass
// with busy high before it takes a command; configuration writes are taken at
// any time.
`default_nettype none

module bitmap_run_allocator_top #(
    parameter int GRANULES      = 128,
    parameter int GRANULE_BYTES = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire bra_pkg::bra_cmd_t           cmd,
    output logic                             done,
    output bra_pkg::bra_rsp_t                result,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [bra_pkg::PCT_W-1:0]   cfg_data
);
    import bra_pkg::*;

    localparam int GW        = $clog2(GRANULES);
    localparam int CW        = $clog2(GRANULES + 1);
    localparam int SEG_BYTES = GRANULES * GRANULE_BYTES;

    // Sequencer codes
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIVN   = 3'd1;
    localparam logic [2:0] S_DIVF   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_WRITE  = 3'd5;
    localparam logic [2:0] S_REPORT = 3'd6;

    logic [2:0]          state_reg,     state_next;
    bra_cmd_t            cmd_reg,       cmd_next;
    logic [DIV_W-1:0]    need_reg,      need_next;
    logic [CW-1:0]       used_reg,      used_next;
    logic                frozen_reg,    frozen_next;
    logic [31:0]         epoch_reg,     epoch_next;
    logic [PCT_W-1:0]    pct_reg,       pct_next;
    logic [CW-1:0]       issue_idx_reg, issue_idx_next;
    logic [GW-1:0]       chk_idx_reg,   chk_idx_next;
    logic                chk_valid_reg, chk_valid_next;
    logic [CW-1:0]       run_reg,       run_next;
    logic [GW-1:0]       start_reg,     start_next;
    logic [CW-1:0]       wr_idx_reg,    wr_idx_next;
    logic [CW-1:0]       wr_end_reg,    wr_end_next;
    logic                wr_val_reg,    wr_val_next;
    logic                report_reg,    report_next;
    logic [STATUS_W-1:0] status_reg,    status_next;
    logic [OFFSET_W-1:0] res_off_reg,   res_off_next;
    logic                done_reg,      done_next;
    bra_rsp_t            rsp_reg,       rsp_next;

    logic [DIV_W-1:0]    dividend;
    logic [DIV_W-1:0]    quotient;
    logic                map_wr_en;
    logic                map_rd_en;
    logic                map_rd_data;
    logic [GW-1:0]       run_start;
    logic [CW-1:0]       run_len;
    logic [15:0]         first_w;
    logic [15:0]         room_w;
    logic [15:0]         need_w;
    logic [15:0]         used_w;
    logic [31:0]         occ_lhs;
    logic [31:0]         occ_rhs;
    logic                in_range;

    // Shared divider: rounded size first, then the free offset
    assign dividend = (state_reg == S_DIVN)
                    ? DIV_W'(cmd_reg.size_bytes) + DIV_W'(GRANULE_BYTES - 1)
                    : DIV_W'(cmd_reg.offset_bytes);

    bra_recip_div #(
        .DIVISOR (GRANULE_BYTES)
    ) u_div (
        .clk      (clk),
        .dividend (dividend),
        .quotient (quotient)
    );

    // Bitmap memory: scan reads and mark writes
    assign map_wr_en = (state_reg == S_WRITE) && (wr_idx_reg != wr_end_reg);
    assign map_rd_en = (state_reg == S_SCAN) && (issue_idx_reg < CW'(GRANULES));

    bra_bitmap #(
        .DEPTH (GRANULES),
        .AW    (GW)
    ) u_map (
        .clk     (clk),
        .wr_en   (map_wr_en),
        .wr_addr (wr_idx_reg[GW-1:0]),
        .wr_data (wr_val_reg),
        .rd_en   (map_rd_en),
        .rd_addr (issue_idx_reg[GW-1:0]),
        .rd_data (map_rd_data)
    );

    // Free range and occupancy terms
    assign first_w  = 16'(quotient[GW-1:0]);
    assign room_w   = 16'(GRANULES) - first_w;
    assign need_w   = 16'(need_reg);
    assign used_w   = 16'(used_reg);
    assign occ_lhs  = 32'(used_reg) * 32'(PCT_SCALE);
    assign occ_rhs  = 32'(pct_reg) * 32'(GRANULES);
    assign in_range = 32'(cmd_reg.offset_bytes) < 32'(SEG_BYTES);

    // Run tracking for the granule whose bit has just been read
    assign run_len   = run_reg + CW'(1);
    assign run_start = (run_reg == '0) ? chk_idx_reg : start_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        need_next      = need_reg;
        used_next      = used_reg;
        frozen_next    = frozen_reg;
        epoch_next     = epoch_reg;
        pct_next       = pct_reg;
        issue_idx_next = issue_idx_reg;
        chk_idx_next   = chk_idx_reg;
        chk_valid_next = 1'b0;
        run_next       = run_reg;
        start_next     = start_reg;
        wr_idx_next    = wr_idx_reg;
        wr_end_next    = wr_end_reg;
        wr_val_next    = wr_val_reg;
        report_next    = report_reg;
        status_next    = status_reg;
        res_off_next   = res_off_reg;
        done_next      = 1'b0;
        rsp_next       = rsp_reg;

        // Take a configuration beat
        if (cfg_valid && cfg_ready)
        begin
            pct_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    state_next = S_DIVN;
                end
            end

            S_DIVN:
            begin
                state_next = S_DIVF;
            end

            S_DIVF:
            begin
                need_next  = quotient;
                state_next = S_DECIDE;
            end

            S_DECIDE:
            begin
                status_next  = STAT_OK;
                res_off_next = '0;
                state_next   = S_REPORT;
                case (cmd_reg.func)
                    FUNC_ALLOC:
                    begin
                        if ((need_reg == '0) || (need_reg > DIV_W'(GRANULES)))
                        begin
                            status_next = STAT_NO_RUN;
                        end
                        else
                        begin
                            issue_idx_next = '0;
                            run_next       = '0;
                            state_next     = S_SCAN;
                        end
                    end

                    FUNC_FREE:
                    begin
                        if (frozen_reg)
                        begin
                            // Acknowledge without freeing
                            status_next = STAT_OK;
                        end
                        else if (!in_range)
                        begin
                            status_next = STAT_RANGE;
                        end
                        else
                        begin
                            wr_idx_next = CW'(first_w);
                            wr_end_next = (need_w >= room_w) ? CW'(GRANULES)
                                                             : CW'(first_w + need_w);
                            wr_val_next = 1'b1;
                            report_next = 1'b1;
                            used_next   = (used_w >= need_w) ? used_reg - CW'(need_reg)
                                                             : '0;
                            state_next  = S_WRITE;
                        end
                    end

                    FUNC_COMPACT:
                    begin
                        epoch_next = epoch_reg + 32'd1;
                        if (occ_lhs > occ_rhs)
                        begin
                            frozen_next = 1'b1;
                        end
                    end

                    default:
                    begin
                        // Clear: empty the segment with a full rewrite pass
                        used_next   = '0;
                        frozen_next = 1'b0;
                        wr_idx_next = '0;
                        wr_end_next = CW'(GRANULES);
                        wr_val_next = 1'b1;
                        report_next = 1'b1;
                        state_next  = S_WRITE;
                    end
                endcase
            end

            S_SCAN:
            begin
                // Issue the next read, check the one that came back
                if (map_rd_en)
                begin
                    issue_idx_next = issue_idx_reg + CW'(1);
                    chk_idx_next   = issue_idx_reg[GW-1:0];
                    chk_valid_next = 1'b1;
                end
                if (chk_valid_reg)
                begin
                    if (map_rd_data)
                    begin
                        run_next   = run_len;
                        start_next = run_start;
                        if (run_len >= need_reg[CW-1:0])
                        begin
                            wr_idx_next    = CW'(run_start);
                            wr_end_next    = CW'(run_start) + need_reg[CW-1:0];
                            wr_val_next    = 1'b0;
                            report_next    = 1'b1;
                            used_next      = used_reg + need_reg[CW-1:0];
                            res_off_next   = OFFSET_W'(32'(run_start)
                                                       * 32'(GRANULE_BYTES));
                            chk_valid_next = 1'b0;
                            state_next     = S_WRITE;
                        end
                        else if (chk_idx_reg == GW'(GRANULES - 1))
                        begin
                            status_next = STAT_NO_RUN;
                            state_next  = S_REPORT;
                        end
                    end
                    else
                    begin
                        run_next = '0;
                        if (chk_idx_reg == GW'(GRANULES - 1))
                        begin
                            status_next = STAT_NO_RUN;
                            state_next  = S_REPORT;
                        end
                    end
                end
            end

            S_WRITE:
            begin
                // Mark one granule a cycle until the end of the range
                if (wr_idx_reg == wr_end_reg)
                begin
                    state_next = report_reg ? S_REPORT : S_IDLE;
                end
                else
                begin
                    wr_idx_next = wr_idx_reg + CW'(1);
                end
            end

            S_REPORT:
            begin
                done_next              = 1'b1;
                rsp_next.status        = status_reg;
                rsp_next.result_offset = res_off_reg;
                rsp_next.used_granules = USED_W'(used_w);
                rsp_next.frozen        = frozen_reg;
                state_next             = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state; reset starts the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_WRITE;
            used_reg      <= '0;
            frozen_reg    <= 1'b0;
            epoch_reg     <= '0;
            pct_reg       <= PCT_RESET;
            issue_idx_reg <= '0;
            chk_valid_reg <= 1'b0;
            run_reg       <= '0;
            wr_idx_reg    <= '0;
            wr_end_reg    <= CW'(GRANULES);
            wr_val_reg    <= 1'b1;
            report_reg    <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            frozen_reg    <= frozen_next;
            epoch_reg     <= epoch_next;
            pct_reg       <= pct_next;
            issue_idx_reg <= issue_idx_next;
            chk_valid_reg <= chk_valid_next;
            run_reg       <= run_next;
            wr_idx_reg    <= wr_idx_next;
            wr_end_reg    <= wr_end_next;
            wr_val_reg    <= wr_val_next;
            report_reg    <= report_next;
            done_reg      <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        need_reg    <= need_next;
        chk_idx_reg <= chk_idx_next;
        start_reg   <= start_next;
        status_reg  <= status_next;
        res_off_reg <= res_off_next;
        rsp_reg     <= rsp_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign result    = rsp_reg;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

>>> sv/bra_checker.sv
// Port-level checks for the bitmap run allocator, bound to the top level.
// Uses bra_pkg; attaches to bitmap_run_allocator_top.
`default_nettype none

module bra_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      start,
    input wire logic                      busy,
    input wire logic                      done,
    input wire bra_pkg::bra_rsp_t         result
);
    import bra_pkg::*;

    // An accepted command beat keeps the block busy on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy low after command beat");

    // A result beat is shown while idle, for one cycle only
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat repeated");

    // Only a successful alloc reports an offset
    a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != STAT_OK)) |-> (result.result_offset == '0))
        else $error("offset on failed command");

    // Status is one of the defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((result.status == STAT_OK) || (result.status == STAT_NO_RUN)
                  || (result.status == STAT_RANGE)))
        else $error("undefined status code");

endmodule

bind bitmap_run_allocator_top bra_checker u_bra_checker (.*);

`default_nettype wire
